/* hw/rtl/fma_pkg.sv */
// ----------------------------------------------------------------------------
// fma_pkg
// Shared widths and constants for the feedback moving average unit.
// ----------------------------------------------------------------------------
package fma_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int WIN_CFG_W      = 5;
    localparam int MAX_WINDOW_DEF = 16;

    localparam logic [WIN_CFG_W-1:0] WINDOW_RESET = WIN_CFG_W'(10);

endpackage

/* hw/rtl/fma_hist_mem.sv */
// ----------------------------------------------------------------------------
// fma_hist_mem
// History ring storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fma_hist_mem #(
    parameter int DEPTH = fma_pkg::MAX_WINDOW_DEF - 1,
    parameter int AW    = 4,
    parameter int DW    = fma_pkg::SAMPLE_W
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/fma_div.sv */
// ----------------------------------------------------------------------------
// fma_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fma_div #(
    parameter int NW = 20,   // dividend / quotient width
    parameter int DW = 5     // divisor width
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [NW-1:0] quotient
);

    localparam int CTW = $clog2(NW + 1);

    logic [DW-1:0]  rem_reg;
    logic [NW-1:0]  quo_reg;
    logic [CTW-1:0] cnt_reg;
    logic           busy_reg;
    logic           done_reg;

    logic [DW:0]    trial;
    logic [DW:0]    diff;
    logic           take;

    assign trial = {rem_reg, quo_reg[NW-1]};
    assign diff  = trial - {1'b0, divisor};
    assign take  = (trial >= {1'b0, divisor});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CTW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CTW'(1);
                if (cnt_reg == CTW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? diff[DW-1:0] : trial[DW-1:0];
            quo_reg <= {quo_reg[NW-2:0], take};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* hw/rtl/feedback_moving_average_unit.sv */
// ----------------------------------------------------------------------------
// feedback_moving_average_unit
// Causal moving average whose history ring holds its own earlier outputs.
// ----------------------------------------------------------------------------
// Each result averages the input beat with use history entries, where use is
// up to MAX_WINDOW-1; the sum width SW is 20 for MAX_WINDOW = 16.
// One item at a time: the next beat is taken the cycle after the result
// registers; history reads (one per cycle) and the serial divider set how long each item takes.
// Reset: window_reg returns to 10, history empty; ring contents undefined.
// ----------------------------------------------------------------------------
module feedback_moving_average_unit #(
    parameter int MAX_WINDOW = fma_pkg::MAX_WINDOW_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [fma_pkg::WIN_CFG_W-1:0]      cfg_wr_data,
    input  logic                               item_valid,
    output logic                               item_ready,
    input  logic [fma_pkg::SAMPLE_W-1:0]       sample,
    input  logic                               first,
    output logic                               result_valid,
    input  logic                               result_ready,
    output logic [fma_pkg::SAMPLE_W-1:0]       filtered
);

    localparam int HDEPTH = MAX_WINDOW - 1;
    localparam int PW     = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;
    localparam int CNTW   = $clog2(MAX_WINDOW);
    localparam int CW     = $clog2(MAX_WINDOW + 1);
    localparam int SW     = fma_pkg::SAMPLE_W + $clog2(MAX_WINDOW);
    localparam int XW     = fma_pkg::SAMPLE_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACC,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t                 state_reg;
    logic [fma_pkg::WIN_CFG_W-1:0] window_reg;
    logic [PW-1:0]          wp_reg;
    logic [CNTW-1:0]        count_reg;
    logic [PW-1:0]          rd_ptr_reg;
    logic [CW-1:0]          issue_left_reg;
    logic                   rd_vld_reg;
    logic [SW-1:0]          total_reg;
    logic [CW-1:0]          divisor_reg;
    logic                   div_start_reg;
    logic                   result_valid_reg;
    logic [XW-1:0]          filtered_reg;

    logic [CW-1:0]          eff_w;
    logic [PW-1:0]          wp_eff;
    logic [CNTW-1:0]        count_eff;
    logic [CW-1:0]          use_cnt;
    logic [PW-1:0]          rd_start;
    logic                   accept;
    logic                   out_free;
    logic                   mem_we;
    logic                   mem_re;
    logic [XW-1:0]          mem_rdata;
    logic                   div_done;
    logic [SW-1:0]          div_quo;
    logic [XW-1:0]          result;

    // effective window: zero acts as one, large values clamp
    always_comb
    begin
        if (window_reg == '0)
            eff_w = CW'(1);
        else if (32'(window_reg) > MAX_WINDOW)
            eff_w = CW'(MAX_WINDOW);
        else
            eff_w = CW'(window_reg);
    end

    assign accept    = item_valid && item_ready;
    assign wp_eff    = first ? '0 : wp_reg;
    assign count_eff = first ? '0 : count_reg;

    always_comb
    begin
        if (CW'(count_eff) > (eff_w - CW'(1)))
            use_cnt = eff_w - CW'(1);
        else
            use_cnt = CW'(count_eff);
    end

    assign rd_start = (wp_eff == '0) ? PW'(HDEPTH - 1) : wp_eff - PW'(1);

    assign out_free = !result_valid_reg || result_ready;
    assign mem_we   = (state_reg == ST_FIN) && out_free;
    assign mem_re   = (state_reg == ST_ACC) && (issue_left_reg != '0);
    assign result   = div_quo[XW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            window_reg       <= fma_pkg::WINDOW_RESET;
            wp_reg           <= '0;
            count_reg        <= '0;
            issue_left_reg   <= '0;
            rd_vld_reg       <= 1'b0;
            div_start_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            if (cfg_wr_en)
            begin
                window_reg <= cfg_wr_data;
            end
            if (result_valid_reg && result_ready)
            begin
                result_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        wp_reg         <= wp_eff;
                        count_reg      <= count_eff;
                        issue_left_reg <= use_cnt;
                        state_reg      <= ST_ACC;
                    end
                end
                ST_ACC:
                begin
                    // one read issued per cycle, data lands in the next cycle
                    rd_vld_reg <= mem_re;
                    if (mem_re)
                    begin
                        issue_left_reg <= issue_left_reg - CW'(1);
                    end
                    else if (!rd_vld_reg)
                    begin
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (out_free)
                    begin
                        result_valid_reg <= 1'b1;
                        wp_reg <= (wp_reg == PW'(HDEPTH - 1)) ? '0 : wp_reg + PW'(1);
                        if (32'(count_reg) < HDEPTH)
                        begin
                            count_reg <= count_reg + CNTW'(1);
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            total_reg   <= SW'(sample);
            divisor_reg <= use_cnt + CW'(1);
            rd_ptr_reg  <= rd_start;
        end
        else if (state_reg == ST_ACC)
        begin
            if (mem_re)
            begin
                rd_ptr_reg <= (rd_ptr_reg == '0) ? PW'(HDEPTH - 1) : rd_ptr_reg - PW'(1);
            end
            if (rd_vld_reg)
            begin
                total_reg <= total_reg + SW'(mem_rdata);
            end
        end
        if (mem_we)
        begin
            filtered_reg <= result;
        end
    end

    fma_hist_mem #(
        .DEPTH (HDEPTH),
        .AW    (PW),
        .DW    (XW)
    ) u_hist (
        .clk   (clk),
        .we    (mem_we),
        .waddr (wp_reg),
        .wdata (result),
        .re    (mem_re),
        .raddr (rd_ptr_reg),
        .rdata (mem_rdata)
    );

    fma_div #(
        .NW (SW),
        .DW (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (total_reg),
        .divisor  (divisor_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign item_ready   = (state_reg == ST_IDLE);
    assign result_valid = result_valid_reg;
    assign filtered     = filtered_reg;

endmodule
